// File: src/hcbd_pkg.sv
package hcbd_pkg;

  localparam int SIZE_BITS = 31;
  localparam int CHUNK_W   = 31;
  localparam int PAT_LEN   = 15;
  localparam int MPOS_W    = 4;

  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_LCA = 8'h61;
  localparam logic [7:0] CH_LCF = 8'h66;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_SIZE    = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_SEEK_CR = 5'b01000,
    PH_SEEK_LF = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    FL_NONE   = 3'b001,
    FL_INSIDE = 3'b010,
    FL_DONE   = 3'b100
  } fl_t;

  typedef enum logic [2:0] {
    STEP_FIRST  = 3'b001,
    STEP_DIGITS = 3'b010,
    STEP_TRAIL  = 3'b100
  } step_t;

  typedef struct packed {
    phase_t                phase;
    logic                  line_all_space;
    fl_t                   first_line;
    logic [MPOS_W-1:0]     match_pos;
    logic                  status_found;
    step_t                 step;
    logic                  size_bad;
    logic [SIZE_BITS-1:0]  size_acc;
    logic [SIZE_BITS-1:0]  body_rem;
  } dec_state_t;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic                  payload_valid;
    logic                  header_end;
    logic                  status_ok;
    logic                  chunk_accepted;
    logic [CHUNK_W-1:0]    chunk_length;
    logic                  size_line_rejected;
    logic                  response_end;
  } dec_result_t;

  function automatic logic [7:0] status_char(input logic [MPOS_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h48;
      4'd1:    ch = 8'h54;
      4'd2:    ch = 8'h54;
      4'd3:    ch = 8'h50;
      4'd4:    ch = 8'h2f;
      4'd5:    ch = 8'h31;
      4'd6:    ch = 8'h2e;
      4'd7:    ch = 8'h31;
      4'd8:    ch = 8'h20;
      4'd9:    ch = 8'h32;
      4'd10:   ch = 8'h30;
      4'd11:   ch = 8'h30;
      4'd12:   ch = 8'h20;
      4'd13:   ch = 8'h4f;
      4'd14:   ch = 8'h4b;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_HT && c <= CH_CR);
  endfunction

  // bit 4 set when c is a lowercase hex digit, value in bits 3:0
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      r = {1'b1, d[3:0]};
    end else if (c >= CH_LCA && c <= CH_LCF) begin
      d = c - CH_LCA + 8'd10;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

endpackage

// File: src/hcbd_step.sv
module hcbd_step
  import hcbd_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  rx_byte,
  output dec_state_t  nxt,
  output dec_result_t res
);

  logic [4:0]           hx;
  logic [SIZE_BITS-1:0] acc_shift;
  logic                 ovf;
  logic [SIZE_BITS-1:0] rem_dec;
  logic [MPOS_W-1:0]    p;
  logic                 is_lf;

  assign hx        = hex_digit(rx_byte);
  assign acc_shift = {cur.size_acc[SIZE_BITS-5:0], hx[3:0]};
  assign ovf       = |cur.size_acc[SIZE_BITS-1 -: 4];
  assign rem_dec   = (cur.body_rem != '0) ? cur.body_rem - 1'b1 : cur.body_rem;
  assign is_lf     = (rx_byte == CH_LF);

  always_comb begin
    nxt = cur;
    res = '0;
    res.data_byte = rx_byte;
    p = '0;

    unique case (cur.phase)
      PH_SIZE: begin
        if (is_lf) begin
          if (cur.step == STEP_FIRST || cur.size_bad) begin
            res.size_line_rejected = 1'b1;
          end else if (cur.size_acc == '0) begin
            res.response_end    = 1'b1;
            nxt.phase           = PH_HEADER;
            nxt.line_all_space  = 1'b1;
            nxt.first_line      = FL_NONE;
            nxt.match_pos       = '0;
            nxt.status_found    = 1'b0;
          end else begin
            res.chunk_accepted = 1'b1;
            res.chunk_length   = CHUNK_W'(cur.size_acc);
            nxt.body_rem       = cur.size_acc;
            nxt.phase          = PH_PAYLOAD;
          end
          nxt.step     = STEP_FIRST;
          nxt.size_bad = 1'b0;
          nxt.size_acc = '0;
        end else begin
          unique case (cur.step)
            STEP_FIRST: begin
              if (!hx[4]) begin
                nxt.size_bad = 1'b1;
                nxt.step     = STEP_TRAIL;
              end else begin
                nxt.size_acc = SIZE_BITS'(hx[3:0]);
                nxt.step     = STEP_DIGITS;
              end
            end
            STEP_DIGITS: begin
              if (!hx[4]) begin
                nxt.step = STEP_TRAIL;
              end else if (!cur.size_bad) begin
                if (ovf) begin
                  nxt.size_bad = 1'b1;
                end else begin
                  nxt.size_acc = acc_shift;
                end
              end
            end
            default: begin
              if (!is_ws(rx_byte)) begin
                nxt.size_bad = 1'b1;
              end
            end
          endcase
        end
      end
      PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        nxt.body_rem      = rem_dec;
        if (rem_dec == '0) begin
          nxt.phase = PH_SEEK_CR;
        end
      end
      PH_SEEK_CR: begin
        if (rx_byte == CH_CR) begin
          nxt.phase = PH_SEEK_LF;
        end
      end
      PH_SEEK_LF: begin
        if (is_lf) begin
          nxt.phase = PH_SIZE;
        end
      end
      default: begin
        nxt.phase = PH_HEADER;
        if (is_lf) begin
          if (cur.line_all_space) begin
            res.header_end     = 1'b1;
            res.status_ok      = cur.status_found;
            nxt.phase          = PH_SIZE;
            nxt.line_all_space = 1'b1;
            nxt.first_line     = FL_NONE;
            nxt.match_pos      = '0;
            nxt.status_found   = 1'b0;
            nxt.step           = STEP_FIRST;
            nxt.size_bad       = 1'b0;
            nxt.size_acc       = '0;
          end else begin
            if (cur.first_line == FL_INSIDE) begin
              nxt.first_line = FL_DONE;
            end
            nxt.line_all_space = 1'b1;
            nxt.match_pos      = '0;
          end
        end else begin
          if (!is_ws(rx_byte)) begin
            nxt.line_all_space = 1'b0;
            if (cur.first_line == FL_NONE) begin
              nxt.first_line = FL_INSIDE;
            end
          end
          if (nxt.first_line != FL_DONE && !cur.status_found) begin
            p = (cur.match_pos < MPOS_W'(PAT_LEN)) ? cur.match_pos : '0;
            if (rx_byte == status_char(p)) begin
              p = p + 1'b1;
            end else begin
              p = (rx_byte == status_char('0)) ? MPOS_W'(1) : '0;
            end
            if (p >= MPOS_W'(PAT_LEN)) begin
              nxt.status_found = 1'b1;
              p = '0;
            end
            nxt.match_pos = p;
          end
        end
      end
    endcase
  end

endmodule

// File: src/http_chunked_body_decoder_core.sv
// HTTP/1.1 chunked body decoder.
// Input channel: one response byte per beat on in_rx_byte, with in_valid and
// in_stall. Result channel: one beat per input byte on the out_ ports, with
// out_valid and out_stall. out_data_byte echoes the byte; the flags mark
// payload bytes, the end of the header (with status_ok), accepted chunk
// sizes (with out_chunk_length), rejected size lines and the end of the
// response.
// The result of a byte is registered and appears in the cycle after its acceptance.
// Throughput: one byte per cycle unless the receiver stalls; the whole decode
// step is one layer of logic between the parser state and result registers.
// Reset (rst_n low at a clock edge) returns the parser to the header phase
// with all tracking cleared and empties the result register.
// When the receiver stalls, the held result stays on the out_ ports and
// in_stall is raised, so no new byte is taken until the result is taken;
// a result register that is empty or being taken does not hold back input.
module http_chunked_body_decoder_core
  import hcbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_data_byte,
  output logic               out_payload_valid,
  output logic               out_header_end,
  output logic               out_status_ok,
  output logic               out_chunk_accepted,
  output logic [CHUNK_W-1:0] out_chunk_length,
  output logic               out_size_line_rejected,
  output logic               out_response_end
);

  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_result_t res_r;
  dec_result_t res_nxt;
  logic        out_valid_r;
  logic        in_take;

  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  hcbd_step u_step (
    .cur     (state_r),
    .rx_byte (in_rx_byte),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase          <= PH_HEADER;
      state_r.line_all_space <= 1'b1;
      state_r.first_line     <= FL_NONE;
      state_r.match_pos      <= '0;
      state_r.status_found   <= 1'b0;
      state_r.step           <= STEP_FIRST;
      state_r.size_bad       <= 1'b0;
      state_r.size_acc       <= '0;
      state_r.body_rem       <= '0;
      out_valid_r            <= 1'b0;
    end else if (in_take) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data_byte          = res_r.data_byte;
  assign out_payload_valid      = res_r.payload_valid;
  assign out_header_end         = res_r.header_end;
  assign out_status_ok          = res_r.status_ok;
  assign out_chunk_accepted     = res_r.chunk_accepted;
  assign out_chunk_length       = res_r.chunk_length;
  assign out_size_line_rejected = res_r.size_line_rejected;
  assign out_response_end       = res_r.response_end;

endmodule
